// ===== design/rmis_pkg.sv =====
// Shared types, constants and code tables for the relay matrix interlock sequencer.
`timescale 1ns / 1ps
`default_nettype none
package rmis_pkg;

  localparam int NUM_CODES   = 68;
  localparam int RELAY_W     = 34;
  localparam int RIDX_W      = 6;
  localparam int CODE_W      = 7;
  localparam int COUNT_W     = 4;
  localparam int DISC_W      = 12;
  localparam int SLOT_W      = 16;
  localparam int SLOT_IDX_W  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RELAY_W-1:0] RELAY_RESET = RELAY_W'((64'd1 << 21) | (64'd1 << 25));
  localparam logic [COUNT_W-1:0] COUNT_SAT   = 4'd15;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_OUTER_MODE = 2'd0;
  localparam logic [1:0] REG_FRAME_HEAD = 2'd1;
  localparam logic [1:0] REG_FRAME_TAIL = 2'd2;

  // Request codes with special handling.
  localparam logic [CODE_W-1:0] CODE_PKTT     = 7'd55;
  localparam logic [CODE_W-1:0] CODE_NKTT     = 7'd61;
  localparam logic [CODE_W-1:0] CODE_FHPO     = 7'd64;
  localparam logic [CODE_W-1:0] CODE_OHPO     = 7'd65;
  localparam logic [CODE_W-1:0] CODE_FHNO     = 7'd66;
  localparam logic [CODE_W-1:0] CODE_OHNO     = 7'd67;
  localparam logic [CODE_W-1:0] CODE_KN_CLOSE = 7'd32;
  localparam logic [CODE_W-1:0] CODE_KI_CLOSE = 7'd44;
  localparam int KN_FIRST = 16;
  localparam int KN_SIZE  = 6;
  localparam int KI_FIRST = 22;
  localparam int KI_SIZE  = 4;
  localparam int NKTT_RELAY = 29;

  // Output slot positions in a job.
  localparam logic [SLOT_IDX_W-1:0] SLOT_HEAD       = 4'd0;
  localparam logic [SLOT_IDX_W-1:0] SLOT_GRP        = 4'd1;
  localparam logic [SLOT_IDX_W-1:0] SLOT_MAIN       = 4'd2;
  localparam logic [SLOT_IDX_W-1:0] SLOT_DISC_LO    = 4'd3;
  localparam logic [SLOT_IDX_W-1:0] SLOT_DISC_HI    = 4'd9;
  localparam logic [SLOT_IDX_W-1:0] SLOT_TAIL       = 4'd15;
  localparam logic [7:0]            DISC_HI_BASE    = 8'h20;

  localparam logic [7:0] CMD_BYTE [NUM_CODES] = '{
    8'h16, 8'h14, 8'h26, 8'h24, 8'h01, 8'h00, 8'h31, 8'h11, 8'h32, 8'h17,
    8'h1f, 8'h1d, 8'h2f, 8'h2d, 8'h08, 8'h09, 8'h38, 8'h18, 8'h3b, 8'h1e,
    8'h15, 8'h13, 8'h27, 8'h25, 8'h12, 8'h10,
    8'h1c, 8'h1a, 8'h2e, 8'h2c, 8'h1b, 8'h19,
    8'h06, 8'h07, 8'h04, 8'h05, 8'h02, 8'h03,
    8'h0f, 8'h0e, 8'h0d, 8'h0c, 8'h0b, 8'h0a,
    8'h37, 8'h36, 8'h35, 8'h34,
    8'h3e, 8'h3f, 8'h3c, 8'h3d,
    8'h23, 8'h20, 8'h21, 8'h33, 8'h22, 8'h30,
    8'h2a, 8'h29, 8'h28, 8'h3a, 8'h2b, 8'h39,
    8'h41, 8'h40, 8'h43, 8'h42
  };

  typedef struct packed {
    logic       outer_mode;
    logic [7:0] frame_head;
    logic [7:0] frame_tail;
  } rmis_cfg_t;

  typedef struct packed {
    logic              head;
    logic              grp_vld;
    logic [7:0]        grp_byte;
    logic              main_vld;
    logic [7:0]        main_byte;
    logic [DISC_W-1:0] disc;
    logic              tail;
  } rmis_job_t;

  function automatic logic [RIDX_W-1:0] relay_of(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] r;
    begin
      if (code < 7'd10)      r = code;
      else if (code < 7'd26) r = code - 7'd10;
      else if (code < 7'd38) r = code - 7'd16;
      else if (code < 7'd48) r = code - 7'd22;
      else if (code < 7'd58) r = code - 7'd26;
      else if (code < 7'd64) r = code - 7'd32;
      else if (code < 7'd66) r = 7'd32;
      else                   r = 7'd33;
      return r[RIDX_W-1:0];
    end
  endfunction

  function automatic logic is_open(input logic [CODE_W-1:0] code);
    begin
      return (code >= 7'd10 && code <= 7'd19) || (code >= 7'd26 && code <= 7'd31) ||
             (code >= 7'd38 && code <= 7'd43) || (code >= 7'd48 && code <= 7'd51) ||
             (code >= 7'd58 && code <= 7'd63) || code == CODE_OHPO || code == CODE_OHNO;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/relay_matrix_interlock_sequencer.sv =====
// Top level of the relay matrix interlock sequencer: config registers and datapath.
`timescale 1ns / 1ps
`default_nettype none
// The front end takes one request beat per cycle whenever its four-entry job
// queue has room, updates the 34-relay map at once and queues the bytes that
// beat causes. The back end emits one byte per cycle while out_ready takes them,
// through a registered output; an item yields one to sixteen bytes (head,
// group close, relay code, up to twelve disconnect codes, tail), and items
// that yield nothing are not queued. The output serializer sets the rate.
module relay_matrix_interlock_sequencer #(
  parameter int MAX_CODES_PER_FRAME = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_func,
  input  wire logic [rmis_pkg::CODE_W-1:0] in_switch_code,
  input  wire logic                        in_batch_end,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_frame_last
);

  rmis_pkg::rmis_cfg_t cfg_r, cfg_nxt;
  rmis_pkg::rmis_job_t push_job;
  rmis_pkg::rmis_job_t head_job;
  logic                q_push;
  logic                q_full;
  logic                q_avail;
  logic                q_pop;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        rmis_pkg::REG_OUTER_MODE: cfg_nxt.outer_mode = pwdata[0];
        rmis_pkg::REG_FRAME_HEAD: cfg_nxt.frame_head = pwdata[7:0];
        rmis_pkg::REG_FRAME_TAIL: cfg_nxt.frame_tail = pwdata[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
    unique case (paddr[3:2])
      rmis_pkg::REG_OUTER_MODE: prdata = {31'd0, cfg_r.outer_mode};
      rmis_pkg::REG_FRAME_HEAD: prdata = {24'd0, cfg_r.frame_head};
      rmis_pkg::REG_FRAME_TAIL: prdata = {24'd0, cfg_r.frame_tail};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.outer_mode <= 1'b0;
      cfg_r.frame_head <= 8'hff;
      cfg_r.frame_tail <= 8'hff;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rmis_front #(
    .MAX_CODES_PER_FRAME(MAX_CODES_PER_FRAME)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_switch_code (in_switch_code),
    .in_batch_end   (in_batch_end),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  rmis_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .avail    (q_avail),
    .pop      (q_pop),
    .head_job (head_job)
  );

  rmis_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_avail        (q_avail),
    .q_job          (head_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_frame_last (out_frame_last)
  );

endmodule
`default_nettype wire

// ===== design/rmis_front.sv =====
// Front end: accepts requests, updates the relay map and builds output jobs.
`timescale 1ns / 1ps
`default_nettype none
module rmis_front #(
  parameter int MAX_CODES_PER_FRAME = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmis_pkg::rmis_cfg_t           cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [rmis_pkg::CODE_W-1:0]   in_switch_code,
  input  wire logic                          in_batch_end,
  input  wire logic                          q_full,
  output logic                               q_push,
  output rmis_pkg::rmis_job_t                q_job
);

  logic [rmis_pkg::RELAY_W-1:0] relay_on_r, relay_on_nxt;
  logic [rmis_pkg::COUNT_W-1:0] codes_sent_r, codes_sent_nxt;
  logic                         stopped_r, stopped_nxt;

  logic                          accept;
  logic                          invalid;
  logic                          skip;
  logic [rmis_pkg::CODE_W-1:0]   code_m;
  logic [rmis_pkg::CODE_W-1:0]   code_k;
  logic [rmis_pkg::RIDX_W-1:0]   ridx;
  logic                          open_req;
  logic                          act;
  logic                          is_ki;
  logic                          is_kn;
  logic                          grp_emit;
  logic [7:0]                    grp_byte;
  logic [rmis_pkg::RELAY_W-1:0]  grp_clr;
  logic                          main_emit;
  logic [rmis_pkg::COUNT_W:0]    sum;
  logic [rmis_pkg::COUNT_W-1:0]  cnt1;
  logic [rmis_pkg::RELAY_W-1:0]  relay_req;
  logic                          has_codes;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    code_m = in_switch_code;
    if (cfg.outer_mode) begin
      if (in_switch_code <= 7'd5)
        code_m = rmis_pkg::CODE_FHPO;
      else if (in_switch_code >= 7'd10 && in_switch_code <= 7'd15)
        code_m = rmis_pkg::CODE_OHPO;
      else if (in_switch_code >= 7'd20 && in_switch_code <= 7'd25)
        code_m = rmis_pkg::CODE_FHNO;
      else if (in_switch_code >= 7'd26 && in_switch_code <= 7'd31)
        code_m = rmis_pkg::CODE_OHNO;
    end
    invalid = in_switch_code >= 7'(rmis_pkg::NUM_CODES);
    code_k  = (code_m == rmis_pkg::CODE_NKTT && relay_on_r[rmis_pkg::NKTT_RELAY]) ?
              rmis_pkg::CODE_PKTT : code_m;
    skip    = invalid || code_m == rmis_pkg::CODE_PKTT ||
              (code_k >= 7'd44 && code_k <= 7'd47) || (code_k >= 7'd32 && code_k <= 7'd37);
    ridx     = rmis_pkg::relay_of(code_k);
    open_req = rmis_pkg::is_open(code_k);
    act      = !stopped_r && !skip && (relay_on_r[ridx] != open_req);
    is_ki    = code_k >= 7'd48 && code_k <= 7'd51;
    is_kn    = code_k >= 7'd38 && code_k <= 7'd43;

    grp_emit = 1'b0;
    grp_byte = 8'h00;
    grp_clr  = '0;
    if (act && is_ki) begin
      for (int i = rmis_pkg::KI_SIZE - 1; i >= 0; i--) begin
        if (relay_on_r[rmis_pkg::KI_FIRST + i]) begin
          grp_emit = 1'b1;
          grp_byte = rmis_pkg::CMD_BYTE[int'(rmis_pkg::CODE_KI_CLOSE) + i];
          grp_clr  = rmis_pkg::RELAY_W'(1) << (rmis_pkg::KI_FIRST + i);
        end
      end
    end
    if (act && is_kn) begin
      for (int i = rmis_pkg::KN_SIZE - 1; i >= 0; i--) begin
        if (relay_on_r[rmis_pkg::KN_FIRST + i]) begin
          grp_emit = 1'b1;
          grp_byte = rmis_pkg::CMD_BYTE[int'(rmis_pkg::CODE_KN_CLOSE) + i];
          grp_clr  = rmis_pkg::RELAY_W'(1) << (rmis_pkg::KN_FIRST + i);
        end
      end
    end
    main_emit = act;

    sum  = {1'b0, codes_sent_r} + {4'd0, grp_emit} + {4'd0, main_emit};
    cnt1 = sum[rmis_pkg::COUNT_W] ? rmis_pkg::COUNT_SAT : sum[rmis_pkg::COUNT_W-1:0];

    relay_req = relay_on_r & ~grp_clr;
    if (main_emit)
      relay_req = relay_req ^ (rmis_pkg::RELAY_W'(1) << ridx);

    has_codes = cnt1 != '0;

    q_job.head      = (grp_emit || main_emit) && codes_sent_r == '0;
    q_job.grp_vld   = grp_emit;
    q_job.grp_byte  = grp_byte;
    q_job.main_vld  = main_emit;
    q_job.main_byte = rmis_pkg::CMD_BYTE[code_k];
    q_job.disc      = (in_batch_end && has_codes && cfg.outer_mode) ?
                      {relay_req[15:10], relay_req[5:0]} : '0;
    q_job.tail      = in_batch_end && has_codes;

    q_push = accept && !in_func && (grp_emit || main_emit || q_job.tail);

    relay_on_nxt   = relay_on_r;
    codes_sent_nxt = codes_sent_r;
    stopped_nxt    = stopped_r;
    if (accept) begin
      if (in_func) begin
        relay_on_nxt = rmis_pkg::RELAY_RESET;
      end else begin
        relay_on_nxt   = relay_req;
        codes_sent_nxt = cnt1;
        stopped_nxt    = stopped_r || (!stopped_r && invalid) ||
                         (main_emit && cnt1 >= rmis_pkg::COUNT_W'(MAX_CODES_PER_FRAME));
        if (in_batch_end) begin
          codes_sent_nxt = '0;
          stopped_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_on_r   <= rmis_pkg::RELAY_RESET;
      codes_sent_r <= '0;
      stopped_r    <= 1'b0;
    end else begin
      relay_on_r   <= relay_on_nxt;
      codes_sent_r <= codes_sent_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/rmis_fifo.sv =====
// Short job queue between the front end and the byte serializer.
`timescale 1ns / 1ps
`default_nettype none
module rmis_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire rmis_pkg::rmis_job_t push_job,
  output logic                     full,
  output logic                     avail,
  input  wire logic                pop,
  output rmis_pkg::rmis_job_t      head_job
);

  rmis_pkg::rmis_job_t            mem_r [rmis_pkg::QUEUE_DEPTH];
  logic [rmis_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rmis_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rmis_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full     = cnt_r == rmis_pkg::QCNT_W'(rmis_pkg::QUEUE_DEPTH);
  assign avail    = cnt_r != '0;
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + rmis_pkg::QCNT_W'(do_push) - rmis_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== design/rmis_back.sv =====
// Back end: serializes queued jobs into frame bytes through an output register.
`timescale 1ns / 1ps
`default_nettype none
module rmis_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rmis_pkg::rmis_cfg_t cfg,
  input  wire logic                q_avail,
  input  wire rmis_pkg::rmis_job_t q_job,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_frame_last
);

  logic [rmis_pkg::SLOT_W-1:0]     pend_r, pend_nxt;
  logic [7:0]                      grp_byte_r, grp_byte_nxt;
  logic [7:0]                      main_byte_r, main_byte_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            out_free;
  logic                            emit;
  logic [rmis_pkg::SLOT_IDX_W-1:0] idx;
  logic [rmis_pkg::SLOT_W-1:0]     pend_after;
  logic [7:0]                      slot_byte;

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_frame_last = out_last_r;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    emit     = (pend_r != '0) && out_free;

    idx = rmis_pkg::SLOT_TAIL;
    for (int i = rmis_pkg::SLOT_W - 1; i >= 0; i--) begin
      if (pend_r[i]) idx = rmis_pkg::SLOT_IDX_W'(i);
    end

    if (idx == rmis_pkg::SLOT_HEAD)
      slot_byte = cfg.frame_head;
    else if (idx == rmis_pkg::SLOT_GRP)
      slot_byte = grp_byte_r;
    else if (idx == rmis_pkg::SLOT_MAIN)
      slot_byte = main_byte_r;
    else if (idx == rmis_pkg::SLOT_TAIL)
      slot_byte = cfg.frame_tail;
    else if (idx < rmis_pkg::SLOT_DISC_HI)
      slot_byte = {4'd0, idx - rmis_pkg::SLOT_DISC_LO};
    else
      slot_byte = rmis_pkg::DISC_HI_BASE + {4'd0, idx - rmis_pkg::SLOT_DISC_HI};

    pend_after = pend_r;
    if (emit)
      pend_after[idx] = 1'b0;

    q_pop         = q_avail && pend_after == '0;
    pend_nxt      = pend_after;
    grp_byte_nxt  = grp_byte_r;
    main_byte_nxt = main_byte_r;
    if (q_pop) begin
      pend_nxt      = {q_job.tail, q_job.disc, q_job.main_vld, q_job.grp_vld, q_job.head};
      grp_byte_nxt  = q_job.grp_byte;
      main_byte_nxt = q_job.main_byte;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = slot_byte;
      out_last_nxt  = idx == rmis_pkg::SLOT_TAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_byte_r  <= grp_byte_nxt;
    main_byte_r <= main_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule
`default_nettype wire
